### rtl/core/cmwc_lag4827_generator_assert.svh
`ifndef CMWC_LAG4827_GENERATOR_ASSERT_SVH
`define CMWC_LAG4827_GENERATOR_ASSERT_SVH

// same-cycle and next-cycle implication checks, clocked on clk, off during reset
`ifndef NO_ASSERTIONS
`define CMWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMWC_ASSERT_NOW(lbl, ante, cons, msg)
`define CMWC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/cmwc_pkg.sv
package cmwc_pkg;

    localparam int WORD_W = 32;

    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    localparam logic [WORD_W-1:0] LCG_MUL    = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_INC    = 32'd13579;
    localparam logic [WORD_W-1:0] CARRY_INIT = 32'd1271;

    localparam int XS_A        = 13;
    localparam int XS_B        = 17;
    localparam int XS_C        = 5;
    localparam int MWC_SHIFT   = 12;
    localparam int CARRY_SHIFT = 20;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] seed_lcg;
        logic [WORD_W-1:0] seed_xorshift;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] random_word;
    } rsp_t;

endpackage

### rtl/core/cmwc_stream_if.sv
interface cmwc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

### rtl/core/cmwc_table.sv
module cmwc_table #(
    parameter int DEPTH = 4827
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [cmwc_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [cmwc_pkg::WORD_W-1:0] rd_data
);

    logic [cmwc_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/cmwc_step.sv
module cmwc_step (
    input  logic [cmwc_pkg::WORD_W-1:0] lcg,
    input  logic [cmwc_pkg::WORD_W-1:0] xsh,
    input  logic [cmwc_pkg::WORD_W-1:0] x,
    input  logic [cmwc_pkg::WORD_W-1:0] carry,
    output logic [cmwc_pkg::WORD_W-1:0] lcg_step,
    output logic [cmwc_pkg::WORD_W-1:0] xsh_step,
    output logic [cmwc_pkg::WORD_W-1:0] seed_word,
    output logic [cmwc_pkg::WORD_W-1:0] carry_step,
    output logic [cmwc_pkg::WORD_W-1:0] draw_word
);

    logic [cmwc_pkg::WORD_W-1:0] xs1;
    logic [cmwc_pkg::WORD_W-1:0] xs2;
    logic [cmwc_pkg::WORD_W-1:0] t;
    logic                        borrow;

    // seeding: lcg and xorshift advance together
    assign lcg_step  = lcg * cmwc_pkg::LCG_MUL + cmwc_pkg::LCG_INC;
    assign xs1       = xsh ^ (xsh << cmwc_pkg::XS_A);
    assign xs2       = xs1 ^ (xs1 >> cmwc_pkg::XS_B);
    assign xsh_step  = xs2 ^ (xs2 << cmwc_pkg::XS_C);
    assign seed_word = lcg_step + xsh_step;

    // draw: complementary multiply-with-carry by 4095
    assign t          = (x << cmwc_pkg::MWC_SHIFT) + carry;
    assign borrow     = (t < x);
    assign carry_step = (x >> cmwc_pkg::CARRY_SHIFT) - cmwc_pkg::WORD_W'(borrow);
    assign draw_word  = ~(t - x);

endmodule

### rtl/core/cmwc_lag4827_generator.sv
// draw: table read on the command beat, then read-modify-write through the shared step unit
// in ST_DRAW; the result is registered once no earlier result is stalled on rsp
// seed: one table entry per cycle in ST_SEED through the whole table, no result
// a new command is taken only back in ST_IDLE, even while an earlier result still waits on rsp
// reset: carry 1271, position 4827, no result pending; table undefined until seeded
`include "cmwc_lag4827_generator_assert.svh"

module cmwc_lag4827_generator #(
    parameter int LAG = 4827
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cmwc_stream_if.sink          cmd,
    cmwc_stream_if.source        rsp
);

    localparam int POS_W  = $clog2(LAG + 1);
    localparam int ADDR_W = $clog2(LAG);
    localparam int W      = cmwc_pkg::WORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   idx_next;
    logic [W-1:0]        carry_reg;
    logic [W-1:0]        carry_next;
    logic [W-1:0]        lcg_reg;
    logic [W-1:0]        lcg_next;
    logic [W-1:0]        xsh_reg;
    logic [W-1:0]        xsh_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [W-1:0]        out_word_reg;
    logic [W-1:0]        out_word_next;

    logic [POS_W-1:0]    pos_adv;
    logic                cmd_fire;
    logic                draw_done;
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [W-1:0]        mem_wr_data;
    logic                mem_rd_en;
    logic [W-1:0]        mem_rd_data;
    logic [W-1:0]        lcg_step;
    logic [W-1:0]        xsh_step;
    logic [W-1:0]        seed_word;
    logic [W-1:0]        carry_step;
    logic [W-1:0]        draw_word;

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign cmd_fire          = cmd.valid && cmd.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.payload.random_word = out_word_reg;

    assign pos_adv   = (pos_reg < POS_W'(LAG - 1)) ? pos_reg + 1'b1 : '0;
    assign draw_done = (state_reg == ST_DRAW) && (!out_valid_reg || rsp.ready);
    assign mem_rd_en = cmd_fire && (cmd.payload.func == cmwc_pkg::FUNC_DRAW);

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = seed_word;
        if (state_reg == ST_SEED)
        begin
            mem_wr_en = 1'b1;
        end
        else if (draw_done)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_reg[ADDR_W-1:0];
            mem_wr_data = draw_word;
        end
    end

    cmwc_table #(
        .DEPTH (LAG)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (pos_adv[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    cmwc_step u_step (
        .lcg        (lcg_reg),
        .xsh        (xsh_reg),
        .x          (mem_rd_data),
        .carry      (carry_reg),
        .lcg_step   (lcg_step),
        .xsh_step   (xsh_step),
        .seed_word  (seed_word),
        .carry_step (carry_step),
        .draw_word  (draw_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        carry_next     = carry_reg;
        lcg_next       = lcg_reg;
        xsh_next       = xsh_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_word_next  = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.payload.func == cmwc_pkg::FUNC_SEED)
                    begin
                        lcg_next   = cmd.payload.seed_lcg;
                        xsh_next   = cmd.payload.seed_xorshift;
                        idx_next   = '0;
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        pos_next   = pos_adv;
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SEED:
            begin
                lcg_next = lcg_step;
                xsh_next = xsh_step;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(LAG - 1))
                begin
                    idx_next   = '0;
                    carry_next = cmwc_pkg::CARRY_INIT;
                    pos_next   = POS_W'(LAG);
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW:
            begin
                if (draw_done)
                begin
                    carry_next     = carry_step;
                    out_word_next  = draw_word;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_W'(LAG);
            idx_reg       <= '0;
            carry_reg     <= cmwc_pkg::CARRY_INIT;
            lcg_reg       <= '0;
            xsh_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            carry_reg     <= carry_next;
            lcg_reg       <= lcg_next;
            xsh_reg       <= xsh_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    `CMWC_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= POS_W'(LAG), "position beyond lag")
    `CMWC_ASSERT_NOW(a_idx_range, state_reg == ST_SEED, idx_reg < ADDR_W'(LAG), "seed index out of range")
    `CMWC_ASSERT_NEXT(a_seed_end, (state_reg == ST_SEED) && (idx_reg == ADDR_W'(LAG - 1)), (pos_reg == POS_W'(LAG)) && (carry_reg == cmwc_pkg::CARRY_INIT) && cmd.ready, "seed end did not restore carry and position")
    `CMWC_ASSERT_NEXT(a_draw_out, draw_done, out_valid_reg && (state_reg == ST_IDLE), "finished draw gave no result beat")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LAG = 4827;
    localparam int RANDOM_ITEMS = 1630;
    localparam int DRAIN_CYCLES = 64;

    logic clk;
    logic rst_n;

    cmwc_stream_if #(.payload_t(cmwc_pkg::cmd_t)) cmd_if ();
    cmwc_stream_if #(.payload_t(cmwc_pkg::rsp_t)) rsp_if ();

    cmwc_lag4827_generator #(
        .LAG(LAG)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_if),
        .rsp(rsp_if)
    );

    localparam logic [cmwc_pkg::WORD_W-1:0] ONES = '1;

    localparam cmwc_pkg::cmd_t DIRECTED_CMDS [19] = '{
        '{cmwc_pkg::FUNC_SEED, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_DRAW, ONES, ONES},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_SEED, ONES, ONES},
        '{cmwc_pkg::FUNC_DRAW, ONES, ONES},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_DRAW, ONES, ONES},
        '{cmwc_pkg::FUNC_SEED, 32'h0000_0000, 32'h0000_0001},
        '{cmwc_pkg::FUNC_SEED, 32'h8000_0000, 32'h8000_0000},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_DRAW, ONES, ONES},
        '{cmwc_pkg::FUNC_SEED, 32'hAAAA_AAAA, 32'h5555_5555},
        '{cmwc_pkg::FUNC_DRAW, 32'h5555_5555, 32'hAAAA_AAAA},
        '{cmwc_pkg::FUNC_DRAW, 32'hAAAA_AAAA, 32'h5555_5555},
        '{cmwc_pkg::FUNC_SEED, 32'h5555_5555, 32'hAAAA_AAAA},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000},
        '{cmwc_pkg::FUNC_DRAW, ONES, ONES},
        '{cmwc_pkg::FUNC_DRAW, 32'h0000_0000, 32'h0000_0000}
    };

    logic [cmwc_pkg::WORD_W-1:0] lag_words [LAG];
    logic [cmwc_pkg::WORD_W-1:0] mwc_carry;
    int                          mwc_pos;

    logic [cmwc_pkg::WORD_W-1:0] expected_words [$];
    int                          mismatch_count;
    int                          send_idle_pct;
    int                          recv_idle_pct;

    task automatic seed_lag_words(input logic [cmwc_pkg::WORD_W-1:0] lcg,
                                  input logic [cmwc_pkg::WORD_W-1:0] xs);
        for (int i = 0; i < LAG; i++)
        begin
            lcg = lcg * cmwc_pkg::LCG_MUL + cmwc_pkg::LCG_INC;
            xs  = xs ^ (xs << cmwc_pkg::XS_A);
            xs  = xs ^ (xs >> cmwc_pkg::XS_B);
            xs  = xs ^ (xs << cmwc_pkg::XS_C);
            lag_words[i] = lcg + xs;
        end
        mwc_carry = cmwc_pkg::CARRY_INIT;
        mwc_pos   = LAG;
    endtask

    function automatic logic [cmwc_pkg::WORD_W-1:0] next_cmwc_word();
        logic [cmwc_pkg::WORD_W-1:0] x;
        logic [cmwc_pkg::WORD_W-1:0] t;
        logic [cmwc_pkg::WORD_W-1:0] r;
        mwc_pos   = (mwc_pos < LAG - 1) ? mwc_pos + 1 : 0;
        x         = lag_words[mwc_pos];
        t         = (x << cmwc_pkg::MWC_SHIFT) + mwc_carry;
        mwc_carry = (x >> cmwc_pkg::CARRY_SHIFT) - {{(cmwc_pkg::WORD_W-1){1'b0}}, (t < x)};
        r         = ~(t - x);
        lag_words[mwc_pos] = r;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic issue_command(input cmwc_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        if (c.func == cmwc_pkg::FUNC_DRAW)
            expected_words.push_back(next_cmwc_word());
        else
            seed_lag_words(c.seed_lcg, c.seed_xorshift);
    endtask

    function automatic cmwc_pkg::cmd_t random_seed_cmd();
        cmwc_pkg::cmd_t c;
        c.func          = cmwc_pkg::FUNC_SEED;
        c.seed_lcg      = $urandom;
        c.seed_xorshift = ($urandom_range(9) == 0) ? '0 : $urandom;
        return c;
    endfunction

    function automatic cmwc_pkg::cmd_t random_draw_cmd();
        cmwc_pkg::cmd_t c;
        c.func          = cmwc_pkg::FUNC_DRAW;
        c.seed_lcg      = $urandom;
        c.seed_xorshift = $urandom;
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // response side: random backpressure, compare each beat with the oldest prediction
    initial
    begin
        logic [cmwc_pkg::WORD_W-1:0] want;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected random_word %h",
                                              rsp_if.payload.random_word));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp_if.payload.random_word !== want)
                        report_mismatch($sformatf("random_word got %h want %h",
                                                  rsp_if.payload.random_word, want));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #30_000_000;
        $display("cmwc_lag4827_generator verification failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        mismatch_count = 0;
        mwc_carry      = cmwc_pkg::CARRY_INIT;
        mwc_pos        = LAG;
        set_idling(32, 65);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_CMDS[i])
            issue_command(DIRECTED_CMDS[i]);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
                set_idling(65, 32);
            else if (k == 2 * RANDOM_ITEMS / 3)
                set_idling(0, 0);
            if ($urandom_range(99) < 2)
                issue_command(random_seed_cmd());
            else
                issue_command(random_draw_cmd());
        end
        cmd_if.valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("cmwc_lag4827_generator verification clean");
        else
            $display("cmwc_lag4827_generator verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cmwc_pkg.sv
rtl/core/cmwc_stream_if.sv
rtl/core/cmwc_table.sv
rtl/core/cmwc_step.sv
rtl/core/cmwc_lag4827_generator.sv
bench/tb.sv
